// ===== sv/ole_pkg.sv =====
`default_nettype none
package ole_pkg;

  localparam int CAPACITY = 256;
  localparam int CW       = $clog2(CAPACITY);     // cell index width
  localparam int NW       = $clog2(CAPACITY + 1); // count width
  localparam int GRP      = 16;                    // cells per group
  localparam int GW       = $clog2(GRP);
  localparam int NGRP     = CAPACITY / GRP;
  localparam int DW       = 32;

  typedef enum logic [3:0] {
    REQ_APPEND     = 4'd0,
    REQ_INSERT     = 4'd1,
    REQ_PREPEND    = 4'd2,
    REQ_CLEAR      = 4'd3,
    REQ_CONTAINS   = 4'd4,
    REQ_GET        = 4'd5,
    REQ_FIRST      = 4'd6,
    REQ_LAST       = 4'd7,
    REQ_INDEXOF    = 4'd8,
    REQ_LASTINDEX  = 4'd9,
    REQ_REMOVEAT   = 4'd10,
    REQ_RMFIRSTOCC = 4'd11,
    REQ_RMFIRST    = 4'd12,
    REQ_RMLAST     = 4'd13,
    REQ_RMLASTOCC  = 4'd14
  } req_t;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_NOTFOUND = 3'd1,
    STAT_BADPOS   = 3'd2,
    STAT_EMPTY    = 3'd3,
    STAT_FULL     = 3'd4
  } stat_t;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_INS  = 2'd1,
    ACT_REM  = 2'd2,
    ACT_CLR  = 2'd3
  } act_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CMP, ST_GRP, ST_RES, ST_RD, ST_WR
  } state_t;

  typedef struct packed {
    act_t            act;
    logic [NW-1:0]   tpos;
    logic [DW-1:0]   nval;
    logic [DW-1:0]   cmp;
    logic [NW-1:0]   cnt;
  } cell_ctl_t;

  typedef struct packed {
    logic            any;
    logic [GW-1:0]   first;
    logic [GW-1:0]   last;
    logic [DW-1:0]   data;
  } grp_res_t;

endpackage
`default_nettype wire

// ===== sv/ole_cell.sv =====
`default_nettype none
module ole_cell
  import ole_pkg::*;
(
  input  wire logic          clk,
  input  wire logic [CW-1:0] idx,
  input  wire cell_ctl_t     ctl,
  input  wire logic [DW-1:0] left_val,
  input  wire logic [DW-1:0] right_val,
  output logic [DW-1:0]      val_r,
  output logic               eq_r,
  output logic [DW-1:0]      rd_val
);

  logic [DW-1:0] val_nxt;
  logic [NW-1:0] my_idx;
  logic          sel;

  assign my_idx = {1'b0, idx};
  assign sel    = (my_idx == ctl.tpos);
  assign rd_val = sel ? val_r : '0;

  always_comb begin
    val_nxt = val_r;
    case (ctl.act)
      ACT_INS: begin
        if (my_idx > ctl.tpos) val_nxt = left_val;
        else if (sel) val_nxt = ctl.nval;
      end
      ACT_REM: begin
        if (my_idx >= ctl.tpos) val_nxt = right_val;
      end
      default: val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    eq_r  <= (val_r == ctl.cmp) && (my_idx < ctl.cnt);
  end

endmodule
`default_nettype wire

// ===== sv/ole_grp.sv =====
`default_nettype none
module ole_grp
  import ole_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic [GRP-1:0]        eq,
  input  wire logic [GRP-1:0][DW-1:0] rd,
  output grp_res_t                   res_r
);

  grp_res_t res_nxt;

  always_comb begin
    res_nxt.any   = |eq;
    res_nxt.first = '0;
    res_nxt.last  = '0;
    res_nxt.data  = '0;
    for (int i = GRP - 1; i >= 0; i--) begin
      if (eq[i]) res_nxt.first = GW'(i);
    end
    for (int i = 0; i < GRP; i++) begin
      if (eq[i]) res_nxt.last = GW'(i);
      res_nxt.data = res_nxt.data | rd[i];
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule
`default_nettype wire

// ===== sv/ordered_list_engine_top.sv =====
`default_nettype none
// Ordered list engine: a row of value cells that shift left or right as one.
// A transaction runs through the compare, group-reduce, decide, read and commit
// steps through the cell row, independent of fill; busy stays high meanwhile, and
// no new transaction is taken until it is through.
// Reset (rst_n low, synchronous) empties the list and drops any pending work;
// the receiver cannot stall, so out_valid is a one-cycle strobe.
module ordered_list_engine_top
  import ole_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [3:0]           in_req_type,
  input  wire logic [8:0]           in_position,
  input  wire logic signed [31:0]   in_item_value,
  output logic                      out_valid,
  output logic [2:0]                out_status,
  output logic signed [31:0]        out_result_value,
  output logic [7:0]                out_found_position,
  output logic [8:0]                out_element_count,
  output logic                      out_is_empty
);

  state_t state_r, state_nxt;

  // latched transaction
  req_t          req_r;
  logic [8:0]    pos_r;
  logic [DW-1:0] val_r;
  logic [NW-1:0] cnt_r, cnt_nxt;

  // decision made in ST_RES
  stat_t         st_r, st_nxt;
  act_t          act_r, act_nxt;
  logic [NW-1:0] tpos_r, tpos_nxt;
  logic          rdv_r, rdv_nxt;
  logic [CW-1:0] fp_r, fp_nxt;

  cell_ctl_t ctl;

  // cell row
  logic [DW-1:0]           cval [CAPACITY];
  logic [CAPACITY-1:0]     ceq;
  logic [DW-1:0]           crd  [CAPACITY];
  grp_res_t                gres [NGRP];

  // commit only in the write step; otherwise cells hold
  assign ctl.act  = (state_r == ST_WR) ? act_r : ACT_NONE;
  assign ctl.tpos = tpos_r;
  assign ctl.nval = val_r;
  assign ctl.cmp  = val_r;
  assign ctl.cnt  = cnt_r;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic [DW-1:0] lv, rv;
      if (gi == 0) begin : g_l0
        assign lv = '0;
      end else begin : g_ln
        assign lv = cval[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_rl
        assign rv = '0;
      end else begin : g_rn
        assign rv = cval[gi+1];
      end
      ole_cell u_cell (
        .clk       (clk),
        .idx       (CW'(gi)),
        .ctl       (ctl),
        .left_val  (lv),
        .right_val (rv),
        .val_r     (cval[gi]),
        .eq_r      (ceq[gi]),
        .rd_val    (crd[gi])
      );
    end

    for (gi = 0; gi < NGRP; gi++) begin : g_grp
      logic [GRP-1:0][DW-1:0] rdg;
      for (genvar k = 0; k < GRP; k++) begin : g_pk
        assign rdg[k] = crd[gi*GRP + k];
      end
      ole_grp u_grp (
        .clk   (clk),
        .eq    (ceq[gi*GRP +: GRP]),
        .rd    (rdg),
        .res_r (gres[gi])
      );
    end
  endgenerate

  // final pick across groups: first and last matching position
  logic          hit_any;
  logic [CW-1:0] hit_first, hit_last, hit_pos;
  logic [DW-1:0] rd_data;
  logic          from_end;

  always_comb begin
    hit_any   = 1'b0;
    hit_first = '0;
    hit_last  = '0;
    rd_data   = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (gres[g].any) hit_first = {(CW-GW)'(g), gres[g].first};
    end
    for (int g = 0; g < NGRP; g++) begin
      hit_any = hit_any | gres[g].any;
      if (gres[g].any) hit_last = {(CW-GW)'(g), gres[g].last};
      rd_data = rd_data | gres[g].data;
    end
  end

  assign from_end = (req_r == REQ_LASTINDEX) || (req_r == REQ_RMLASTOCC);
  assign hit_pos  = from_end ? hit_last : hit_first;

  // decision logic
  logic full, empty;
  assign full  = (cnt_r == NW'(CAPACITY));
  assign empty = (cnt_r == '0);

  always_comb begin
    st_nxt   = st_r;
    act_nxt  = act_r;
    tpos_nxt = tpos_r;
    rdv_nxt  = rdv_r;
    fp_nxt   = fp_r;
    if (state_r == ST_RES) begin
      st_nxt   = STAT_OK;
      act_nxt  = ACT_NONE;
      tpos_nxt = '0;
      rdv_nxt  = 1'b0;
      fp_nxt   = '0;
      case (req_r)
        REQ_APPEND, REQ_PREPEND: begin
          if (full) st_nxt = STAT_FULL;
          else begin
            act_nxt  = ACT_INS;
            tpos_nxt = (req_r == REQ_APPEND) ? cnt_r : '0;
          end
        end
        REQ_INSERT: begin
          if (full) st_nxt = STAT_FULL;
          else if (NW'(pos_r) > cnt_r) st_nxt = STAT_BADPOS;
          else begin
            act_nxt  = ACT_INS;
            tpos_nxt = NW'(pos_r);
          end
        end
        REQ_CLEAR: act_nxt = ACT_CLR;
        REQ_CONTAINS: begin
          if (!hit_any) st_nxt = STAT_NOTFOUND;
        end
        REQ_GET, REQ_REMOVEAT: begin
          if (NW'(pos_r) >= cnt_r) st_nxt = STAT_BADPOS;
          else begin
            rdv_nxt  = 1'b1;
            tpos_nxt = NW'(pos_r);
            if (req_r == REQ_REMOVEAT) act_nxt = ACT_REM;
          end
        end
        REQ_FIRST, REQ_LAST, REQ_RMFIRST, REQ_RMLAST: begin
          if (empty) st_nxt = STAT_EMPTY;
          else begin
            rdv_nxt  = 1'b1;
            tpos_nxt = ((req_r == REQ_FIRST) || (req_r == REQ_RMFIRST)) ? '0
                                                                         : cnt_r - 1'b1;
            if ((req_r == REQ_RMFIRST) || (req_r == REQ_RMLAST)) act_nxt = ACT_REM;
          end
        end
        REQ_INDEXOF, REQ_LASTINDEX: begin
          if (!hit_any) st_nxt = STAT_NOTFOUND;
          else fp_nxt = hit_pos;
        end
        REQ_RMFIRSTOCC, REQ_RMLASTOCC: begin
          if (!hit_any) st_nxt = STAT_NOTFOUND;
          else begin
            rdv_nxt  = 1'b1;
            act_nxt  = ACT_REM;
            tpos_nxt = {1'b0, hit_pos};
          end
        end
        default: st_nxt = STAT_OK; // unused code: no change, zeros
      endcase
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (state_r == ST_WR) begin
      case (act_r)
        ACT_INS: cnt_nxt = cnt_r + 1'b1;
        ACT_REM: cnt_nxt = cnt_r - 1'b1;
        ACT_CLR: cnt_nxt = '0;
        default: cnt_nxt = cnt_r;
      endcase
    end
  end

  // next state
  always_comb begin
    case (state_r)
      ST_IDLE: state_nxt = start ? ST_CMP : ST_IDLE;
      ST_CMP:  state_nxt = ST_GRP;
      ST_GRP:  state_nxt = ST_RES;
      ST_RES:  state_nxt = ST_RD;
      ST_RD:   state_nxt = ST_WR;
      ST_WR:   state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    case (state_r)
      ST_IDLE: busy = 1'b0;
      default: busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      out_valid <= (state_r == ST_WR);
    end
  end

  always_ff @(posedge clk) begin
    st_r   <= st_nxt;
    act_r  <= act_nxt;
    tpos_r <= tpos_nxt;
    rdv_r  <= rdv_nxt;
    fp_r   <= fp_nxt;
    if ((state_r == ST_IDLE) && start) begin
      req_r <= req_t'(in_req_type);
      pos_r <= in_position;
      val_r <= in_item_value;
    end
    if (state_r == ST_WR) begin
      out_status         <= st_r;
      out_result_value   <= rdv_r ? rd_data : '0;
      out_found_position <= 8'(fp_r);
      out_element_count  <= 9'(cnt_nxt);
      out_is_empty       <= (cnt_nxt == '0);
    end
  end

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= NW'(CAPACITY)) else $error("count above capacity");

  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_WR)) else $error("stray result strobe");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_empty == (out_element_count == '0)))
    else $error("empty flag mismatch");

  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("busy not raised");

endmodule
`default_nettype wire
